// ===== hw/rtl/fbp_pkg.sv =====
// ----------------------------------------------------------------------------
// fbp_pkg
// Shared types and codes for the bitstream file parser.
// ----------------------------------------------------------------------------
package fbp_pkg;

  localparam int PREAMBLE_BYTES_DEF = 13;

  // key bytes
  localparam logic [7:0] KEY_A = 8'h61;
  localparam logic [7:0] KEY_D = 8'h64;
  localparam logic [7:0] KEY_E = 8'h65;

  // field codes
  localparam logic [2:0] FC_UNKNOWN = 3'd4;
  localparam logic [2:0] FC_CONFIG  = 3'd5;

  // status codes
  localparam logic [1:0] ST_BUSY     = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_EARLY    = 2'd2;
  localparam logic [1:0] ST_TRAILING = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] field_code;
    logic       last_of_field;
    logic [1:0] status;
  } fbp_result_t;

endpackage

// ===== hw/rtl/fbp_parse.sv =====
// ----------------------------------------------------------------------------
// fbp_parse
// Parser state and per-word decode; one word handled per accepted cycle.
// ----------------------------------------------------------------------------
module fbp_parse #(
  parameter int PREAMBLE_BYTES = fbp_pkg::PREAMBLE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                end_of_file,
  input  logic                reverse_bits,
  output logic                emit,
  output fbp_pkg::fbp_result_t result
);

  localparam int PRE_W = (PREAMBLE_BYTES < 1) ? 1 : $clog2(PREAMBLE_BYTES + 1);

  typedef enum logic [2:0] {
    PH_PRE, PH_KEY, PH_LEN16, PH_CONTENT, PH_LEN32, PH_DATA, PH_AWAIT, PH_DRAIN
  } phase_t;

  phase_t            phase, phase_next, phase_eff;
  logic [PRE_W-1:0]  pre_cnt, pre_cnt_next;
  logic [31:0]       byte_counter, byte_counter_next;
  logic [23:0]       length_shift, length_shift_next;
  logic [1:0]        length_byte_index, length_byte_index_next;
  logic [2:0]        current_field, current_field_next;
  logic [31:0]       len32;
  logic              silent;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

  assign len32 = {length_shift, in_byte};

  always_comb begin
    phase_next             = phase;
    pre_cnt_next           = pre_cnt;
    byte_counter_next      = byte_counter;
    length_shift_next      = length_shift;
    length_byte_index_next = length_byte_index;
    current_field_next     = current_field;
    emit                   = 1'b0;
    silent                 = 1'b0;
    result                 = '0;

    phase_eff = phase;
    if (phase == PH_PRE && pre_cnt >= PRE_W'(PREAMBLE_BYTES)) begin
      phase_eff = PH_KEY;
    end

    case (phase_eff)
      PH_PRE: begin
        pre_cnt_next = pre_cnt + 1'b1;
      end
      PH_KEY: begin
        if (in_byte >= fbp_pkg::KEY_A && in_byte <= fbp_pkg::KEY_D) begin
          current_field_next = 3'(in_byte - fbp_pkg::KEY_A);
        end else if (in_byte == fbp_pkg::KEY_E) begin
          current_field_next = fbp_pkg::FC_CONFIG;
        end else begin
          current_field_next = fbp_pkg::FC_UNKNOWN;
        end
        length_shift_next      = '0;
        length_byte_index_next = '0;
        phase_next = (in_byte == fbp_pkg::KEY_E) ? PH_LEN32 : PH_LEN16;
      end
      PH_LEN16: begin
        if (length_byte_index == 2'd1) begin
          length_byte_index_next = '0;
          byte_counter_next      = {16'd0, length_shift[7:0], in_byte};
          length_shift_next      = {8'd0, length_shift[7:0], in_byte};
          phase_next = ({length_shift[7:0], in_byte} == 16'd0) ? PH_KEY : PH_CONTENT;
        end else begin
          length_byte_index_next = 2'd1;
          length_shift_next      = {16'd0, in_byte};
        end
      end
      PH_CONTENT: begin
        emit              = 1'b1;
        result.byte_valid = 1'b1;
        result.out_byte   = in_byte;
        byte_counter_next = byte_counter - 1'b1;
        if (byte_counter == 32'd1) begin
          result.last_of_field = 1'b1;
          phase_next           = PH_KEY;
        end
      end
      PH_LEN32: begin
        length_shift_next = len32[23:0];
        if (length_byte_index == 2'd3) begin
          length_byte_index_next = '0;
          byte_counter_next      = len32;
          if (len32 == 32'd0) begin
            if (end_of_file) begin
              emit                 = 1'b1;
              result.last_of_field = 1'b1;
              result.status        = fbp_pkg::ST_DONE;
            end else begin
              phase_next = PH_AWAIT;
            end
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          length_byte_index_next = length_byte_index + 1'b1;
        end
      end
      PH_DATA: begin
        emit              = 1'b1;
        result.byte_valid = 1'b1;
        result.out_byte   = reverse_bits ? rev8(in_byte) : in_byte;
        byte_counter_next = byte_counter - 1'b1;
        if (byte_counter == 32'd1) begin
          result.last_of_field = 1'b1;
          if (end_of_file) begin
            result.status = fbp_pkg::ST_DONE;
          end else begin
            phase_next = PH_AWAIT;
          end
        end
      end
      PH_AWAIT: begin
        emit          = 1'b1;
        result.status = fbp_pkg::ST_TRAILING;
        phase_next    = PH_DRAIN;
      end
      default: begin
        silent = 1'b1;
      end
    endcase

    result.field_code = current_field_next;

    if (end_of_file) begin
      if (result.status == fbp_pkg::ST_BUSY && !silent) begin
        result.status = fbp_pkg::ST_EARLY;
        emit          = 1'b1;
      end
      phase_next             = PH_PRE;
      pre_cnt_next           = '0;
      byte_counter_next      = '0;
      length_shift_next      = '0;
      length_byte_index_next = '0;
      current_field_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_PRE;
      pre_cnt           <= '0;
      byte_counter      <= '0;
      length_shift      <= '0;
      length_byte_index <= '0;
      current_field     <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      pre_cnt           <= pre_cnt_next;
      byte_counter      <= byte_counter_next;
      length_shift      <= length_shift_next;
      length_byte_index <= length_byte_index_next;
      current_field     <= current_field_next;
    end
  end

endmodule

// ===== hw/rtl/fbp_out_stage.sv =====
// ----------------------------------------------------------------------------
// fbp_out_stage
// Result register on the output stream; stalls the input while a word waits untaken.
// ----------------------------------------------------------------------------
module fbp_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  fbp_pkg::fbp_result_t result,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fbp_pkg::fbp_result_t out_result
);

  assign ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      out_result <= result;
    end
  end

endmodule

// ===== hw/rtl/fpga_bitstream_file_parser_unit.sv =====
// ----------------------------------------------------------------------------
// fpga_bitstream_file_parser_unit
// Splits a bitstream file into header fields and configuration data.
// ----------------------------------------------------------------------------
// Input stream s_axis: one file byte per word, tlast on the file's final byte.
// Output stream m_axis: at most one word per input word; field content bytes,
// configuration bytes (optionally bit-reversed), and status words for file
// completion, premature end and trailing data. tlast marks the final byte of
// a field or completion; tuser carries byte_valid and the field code.
// cfg_wr_en/cfg_wr_data set the bit-reverse control; write only while idle.
// A result is registered and appears on m_axis in the cycle after its input word.
// Throughput: one input word per cycle while m_axis takes its words; the parser
// state updates once per accepted word and the one-deep output register lets
// the next word in while a result is taken in the same cycle.
// When m_axis stalls with a word held, s_axis_tready drops until it is taken.
// Reset clears the parser to the preamble phase and the control bit to 0;
// after each tlast the parser rearms for a new file, keeping the control bit.
// ----------------------------------------------------------------------------
module fpga_bitstream_file_parser_unit #(
  parameter int PREAMBLE_BYTES = fbp_pkg::PREAMBLE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status, rest 0
  output logic [3:0]  m_axis_tuser,   // [0] byte_valid, [3:1] field_code
  output logic        m_axis_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  logic                 reverse_bits;
  logic                 accept;
  logic                 emit;
  fbp_pkg::fbp_result_t result;
  fbp_pkg::fbp_result_t out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_bits <= 1'b0;
    end else if (cfg_wr_en) begin
      reverse_bits <= cfg_wr_data;
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  fbp_parse #(
    .PREAMBLE_BYTES(PREAMBLE_BYTES)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (s_axis_tdata),
    .end_of_file  (s_axis_tlast),
    .reverse_bits (reverse_bits),
    .emit         (emit),
    .result       (result)
  );

  fbp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && emit),
    .result     (result),
    .ready      (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (out_result)
  );

  assign m_axis_tdata = {6'd0, out_result.status, out_result.out_byte};
  assign m_axis_tuser = {out_result.field_code, out_result.byte_valid};
  assign m_axis_tlast = out_result.last_of_field;

endmodule

// ===== hw/rtl/fbp_checker.sv =====
// ----------------------------------------------------------------------------
// fbp_checker
// Port-level checks on the parser's output stream.
// ----------------------------------------------------------------------------
module fbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("data byte set on a status-only word");

  a_trailing: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[9:8] == fbp_pkg::ST_TRAILING
      |-> !m_axis_tuser[0] && !m_axis_tlast)
    else $error("trailing-data word carries a byte or last flag");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[9:8] == fbp_pkg::ST_DONE
      |-> m_axis_tlast && m_axis_tuser[3:1] == fbp_pkg::FC_CONFIG)
    else $error("completion word without last flag or config code");

endmodule

bind fpga_bitstream_file_parser_unit fbp_checker u_fbp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/fpga_bitstream_file_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// fpga_bitstream_file_parser_unit_tb
// Streams bitstream files (well-formed, truncated, with trailing bytes, with
// corrupt lengths, and plain noise) through the parser with random idle bursts
// on both sides. A built-in parse tracker predicts every output word, and
// each accepted word is compared field by field. The bit-reverse control is
// rewritten between phases, with the parser idle.
// ----------------------------------------------------------------------------
module fpga_bitstream_file_parser_unit_tb;

  localparam int PHASE_ITEMS = 210;
  localparam int NUM_PHASES  = 5;

  localparam int F_GOOD     = 0;
  localparam int F_TRAILING = 1;
  localparam int F_TRUNC    = 2;
  localparam int F_WILD     = 3;
  localparam int F_NOISE    = 4;

  typedef enum logic [2:0] {
    P_PREAMBLE, P_KEY, P_LEN16, P_CONTENT, P_LEN32, P_CONFIG, P_AWAIT_END, P_DRAIN
  } parse_phase_t;

  class bitfile_parse_tracker;
    parse_phase_t         phase;
    logic [31:0]          left;
    logic [31:0]          len_acc;
    logic [1:0]           len_idx;
    logic [2:0]           field;
    logic                 reverse;
    fbp_pkg::fbp_result_t parsed_words[$];

    function void rearm();
      phase   = P_PREAMBLE;
      left    = '0;
      len_acc = '0;
      len_idx = '0;
      field   = '0;
    endfunction

    function void reset();
      reverse = 1'b0;
      parsed_words.delete();
      rearm();
    endfunction

    function int pending();
      return parsed_words.size();
    endfunction

    function void note_input(logic [7:0] b, logic eof);
      fbp_pkg::fbp_result_t r;
      logic        emit;
      logic        silent;
      logic [7:0]  flipped;
      r = '0;
      emit = 1'b0;
      silent = 1'b0;
      for (int k = 0; k < 8; k++) flipped[k] = b[7-k];
      if (phase == P_PREAMBLE && left >= fbp_pkg::PREAMBLE_BYTES_DEF) begin
        phase = P_KEY;
        left  = '0;
      end
      case (phase)
        P_PREAMBLE: left = left + 1;
        P_KEY: begin
          if (b >= fbp_pkg::KEY_A && b <= fbp_pkg::KEY_D) field = 3'(b - fbp_pkg::KEY_A);
          else if (b == fbp_pkg::KEY_E) field = fbp_pkg::FC_CONFIG;
          else field = fbp_pkg::FC_UNKNOWN;
          len_acc = '0;
          len_idx = '0;
          phase = (b == fbp_pkg::KEY_E) ? P_LEN32 : P_LEN16;
        end
        P_LEN16: begin
          len_acc = {16'h0, len_acc[7:0], b};
          if (len_idx == 2'd1) begin
            len_idx = '0;
            left = len_acc;
            phase = (left == 0) ? P_KEY : P_CONTENT;
          end else begin
            len_idx = 2'd1;
          end
        end
        P_CONTENT: begin
          emit = 1'b1;
          r.byte_valid = 1'b1;
          r.out_byte = b;
          left = left - 1;
          if (left == 0) begin
            r.last_of_field = 1'b1;
            phase = P_KEY;
          end
        end
        P_LEN32: begin
          len_acc = {len_acc[23:0], b};
          if (len_idx == 2'd3) begin
            len_idx = '0;
            left = len_acc;
            if (left == 0) begin
              // empty configuration data
              if (eof) begin
                emit = 1'b1;
                r.last_of_field = 1'b1;
                r.status = fbp_pkg::ST_DONE;
              end else begin
                phase = P_AWAIT_END;
              end
            end else begin
              phase = P_CONFIG;
            end
          end else begin
            len_idx = len_idx + 2'd1;
          end
        end
        P_CONFIG: begin
          emit = 1'b1;
          r.byte_valid = 1'b1;
          r.out_byte = reverse ? flipped : b;
          left = left - 1;
          if (left == 0) begin
            r.last_of_field = 1'b1;
            if (eof) r.status = fbp_pkg::ST_DONE;
            else phase = P_AWAIT_END;
          end
        end
        P_AWAIT_END: begin
          emit = 1'b1;
          r.status = fbp_pkg::ST_TRAILING;
          phase = P_DRAIN;
        end
        default: silent = 1'b1;
      endcase
      r.field_code = field;
      if (eof) begin
        if (r.status == fbp_pkg::ST_BUSY && !silent) begin
          r.status = fbp_pkg::ST_EARLY;
          emit = 1'b1;
        end
        rearm();
      end
      if (emit) parsed_words.push_back(r);
    endfunction

    function bit check_word(logic [15:0] data, logic [3:0] user, logic last,
                            output string msg);
      fbp_pkg::fbp_result_t got;
      fbp_pkg::fbp_result_t exp;
      got.out_byte      = data[7:0];
      got.status        = data[9:8];
      got.byte_valid    = user[0];
      got.field_code    = user[3:1];
      got.last_of_field = last;
      msg = "";
      if (parsed_words.size() == 0) begin
        msg = $sformatf("unexpected word: byte %02h v%0b fc%0d last%0b st%0d",
                        got.out_byte, got.byte_valid, got.field_code,
                        got.last_of_field, got.status);
        return 1'b0;
      end
      exp = parsed_words.pop_front();
      if (got !== exp) begin
        msg = $sformatf({"word mismatch: got byte %02h v%0b fc%0d last%0b st%0d,",
                         " expected byte %02h v%0b fc%0d last%0b st%0d"},
                        got.out_byte, got.byte_valid, got.field_code,
                        got.last_of_field, got.status,
                        exp.out_byte, exp.byte_valid, exp.field_code,
                        exp.last_of_field, exp.status);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] in_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;        // [7:0] out_byte, [9:8] status
  logic [3:0]  m_axis_tuser;        // [0] byte_valid, [3:1] field_code
  logic        m_axis_tlast;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;

  bitfile_parse_tracker tracker = new();
  int errors = 0;
  int items_sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;

  fpga_bitstream_file_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // output side stalls
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_hold <= $urandom_range(0, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    string msg;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (!tracker.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast, msg))
        report(msg);
    end
  end

  task automatic send_word(logic [7:0] b, logic eof);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eof;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_input(b, eof);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.reverse = v;
  endtask

  task automatic send_file(int kind);
    logic [7:0] q[$];
    logic [7:0] key;
    int len;
    int cut;
    if (kind == F_NOISE) begin
      repeat ($urandom_range(1, 40)) q.push_back(8'($urandom));
    end else begin
      repeat (fbp_pkg::PREAMBLE_BYTES_DEF) q.push_back(8'($urandom));
      if (kind == F_WILD) begin
        // corrupt lengths, cut short
        key = ($urandom_range(0, 3) == 0) ? fbp_pkg::KEY_E : 8'($urandom);
        q.push_back(key);
        repeat ((key == fbp_pkg::KEY_E) ? 4 : 2) q.push_back(8'($urandom));
        repeat ($urandom_range(0, 20)) q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 5) < 4) begin
            key = fbp_pkg::KEY_A + 8'($urandom_range(0, 3));
          end else begin
            do key = 8'($urandom); while (key == fbp_pkg::KEY_E);
          end
          len = $urandom_range(0, 6);
          q.push_back(key);
          q.push_back(8'(len >> 8));
          q.push_back(8'(len));
          repeat (len) q.push_back(8'($urandom));
        end
        len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
        q.push_back(fbp_pkg::KEY_E);
        for (int k = 3; k >= 0; k--) q.push_back(8'(len >> (8 * k)));
        repeat (len) q.push_back(8'($urandom));
        if (kind == F_TRAILING) repeat ($urandom_range(1, 5)) q.push_back(8'($urandom));
        if (kind == F_TRUNC) begin
          cut = $urandom_range(1, q.size() - 1);
          while (q.size() > cut) q.pop_back();
        end
      end
    end
    foreach (q[i]) send_word(q[i], i == q.size() - 1);
  endtask

  initial begin
    int pick;
    int kind;
    tracker.reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // end flag on the very first byte
    send_word(8'h00, 1'b1);
    // minimal file: empty configuration data closed on its length
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    repeat (fbp_pkg::PREAMBLE_BYTES_DEF - 2) send_word(8'($urandom), 1'b0);
    send_word(fbp_pkg::KEY_E, 1'b0);
    repeat (3) send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b1);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_cfg(p[0] == 1'b0);
      tx_idle_pct = (p == NUM_PHASES - 1 || p == 2) ? 0 : 8 + 8 * p;
      rx_idle_pct = (p == NUM_PHASES - 1 || p == 1) ? 0 : 6 + 4 * p;
      while (items_sent < (p + 1) * PHASE_ITEMS + 20) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) kind = F_GOOD;
        else if (pick < 60) kind = F_TRAILING;
        else if (pick < 80) kind = F_TRUNC;
        else if (pick < 92) kind = F_WILD;
        else kind = F_NOISE;
        send_file(kind);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
